### hdl/tolre_pkg.sv
// shared types, constants and text tables for the telnet line server
// no dependencies; used by every module of the block
`default_nettype none

package tolre_pkg;

    localparam int LINE_LEN    = 36;
    localparam int FILL_W      = $clog2(LINE_LEN);
    localparam int ADDR_W      = FILL_W;
    localparam int IDX_W       = (FILL_W > 4) ? FILL_W : 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CMD_IAC  = 8'd255;
    localparam logic [7:0] CMD_WILL = 8'd251;
    localparam logic [7:0] CMD_WONT = 8'd252;
    localparam logic [7:0] CMD_DO   = 8'd253;
    localparam logic [7:0] CMD_DONT = 8'd254;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;

    typedef enum logic [2:0] {
        PS_NORMAL,
        PS_IAC,
        PS_WILL,
        PS_WONT,
        PS_DO,
        PS_DONT,
        PS_CLOSED
    } parse_state_t;

    typedef enum logic [2:0] {
        JOB_OPEN,
        JOB_REF_DONT,
        JOB_REF_WONT,
        JOB_ECHO,
        JOB_QUIT
    } job_kind_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_OPEN,
        PH_REFUSE,
        PH_LINE,
        PH_CRLF,
        PH_PROMPT,
        PH_BYE
    } phase_t;

    typedef struct packed {
        job_kind_t         kind;
        logic [7:0]        arg;
        logic [FILL_W-1:0] len;
    } job_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } line_wr_t;

    function automatic logic [7:0] quit_char(input logic [1:0] i);
        logic [7:0] c;
        unique case (i)
            2'd0:    c = 8'h71;
            2'd1:    c = 8'h75;
            2'd2:    c = 8'h69;
            default: c = 8'h74;
        endcase
        return c;
    endfunction

    // greeting sent when a connection opens
    function automatic logic [7:0] open_char(input logic [2:0] i);
        logic [7:0] c;
        unique case (i)
            3'd0:    c = 8'h62;
            3'd1:    c = 8'h65;
            3'd2:    c = 8'h65;
            3'd3:    c = 8'h3e;
            default: c = 8'h20;
        endcase
        return c;
    endfunction

    // "wizard> "
    function automatic logic [7:0] prompt_char(input logic [2:0] i);
        logic [7:0] c;
        unique case (i)
            3'd0:    c = 8'h77;
            3'd1:    c = 8'h69;
            3'd2:    c = 8'h7a;
            3'd3:    c = 8'h61;
            3'd4:    c = 8'h72;
            3'd5:    c = 8'h64;
            3'd6:    c = 8'h3e;
            default: c = 8'h20;
        endcase
        return c;
    endfunction

    // "goodbye" then cr lf
    function automatic logic [7:0] bye_char(input logic [3:0] i);
        logic [7:0] c;
        unique case (i)
            4'd0:    c = 8'h67;
            4'd1:    c = 8'h6f;
            4'd2:    c = 8'h6f;
            4'd3:    c = 8'h64;
            4'd4:    c = 8'h62;
            4'd5:    c = 8'h79;
            4'd6:    c = 8'h65;
            4'd7:    c = CH_CR;
            default: c = CH_LF;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### hdl/tolre_front.sv
// front end: telnet command parser, line gathering and job issue
// depends on tolre_pkg
`default_nettype none

module tolre_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,
    input  wire logic              s_tuser,
    input  wire logic              q_full,
    output logic                   q_push,
    output tolre_pkg::job_t        q_job,
    output tolre_pkg::line_wr_t    line_wr,
    input  wire logic              echo_done
);

    tolre_pkg::parse_state_t          parse_reg, parse_next;
    logic [tolre_pkg::FILL_W-1:0]     fill_reg, fill_next;
    logic                             match_reg, match_next;
    logic                             pend_reg, pend_next;

    logic accept;
    logic take_data;
    logic line_end;
    logic store;
    logic quit_hit;

    // no word while an echo is still reading the line store
    assign s_tready = !q_full && !pend_reg;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        take_data = !s_tuser &&
                    (((parse_reg == tolre_pkg::PS_NORMAL) && (s_tdata != tolre_pkg::CMD_IAC)) ||
                     ((parse_reg == tolre_pkg::PS_IAC) && (s_tdata == tolre_pkg::CMD_IAC)));
        line_end  = take_data && (s_tdata != tolre_pkg::CH_CR) &&
                    ((s_tdata == tolre_pkg::CH_LF) ||
                     (fill_reg == tolre_pkg::FILL_W'(tolre_pkg::LINE_LEN - 1)));
        store     = take_data && (s_tdata != tolre_pkg::CH_CR) && !line_end;
        quit_hit  = line_end && match_reg && (fill_reg == tolre_pkg::FILL_W'(4));
    end

    // next state
    always_comb begin
        parse_next = parse_reg;
        fill_next  = fill_reg;
        match_next = match_reg;
        pend_next  = pend_reg;
        if (echo_done) begin
            pend_next = 1'b0;
        end
        if (accept) begin
            if (s_tuser) begin
                parse_next = tolre_pkg::PS_NORMAL;
                fill_next  = '0;
                match_next = 1'b0;
            end else begin
                unique case (parse_reg)
                    tolre_pkg::PS_NORMAL: begin
                        if (s_tdata == tolre_pkg::CMD_IAC) begin
                            parse_next = tolre_pkg::PS_IAC;
                        end
                    end
                    tolre_pkg::PS_IAC: begin
                        priority if (s_tdata == tolre_pkg::CMD_WILL) begin
                            parse_next = tolre_pkg::PS_WILL;
                        end else if (s_tdata == tolre_pkg::CMD_WONT) begin
                            parse_next = tolre_pkg::PS_WONT;
                        end else if (s_tdata == tolre_pkg::CMD_DO) begin
                            parse_next = tolre_pkg::PS_DO;
                        end else if (s_tdata == tolre_pkg::CMD_DONT) begin
                            parse_next = tolre_pkg::PS_DONT;
                        end else begin
                            parse_next = tolre_pkg::PS_NORMAL;
                        end
                    end
                    tolre_pkg::PS_WILL, tolre_pkg::PS_WONT,
                    tolre_pkg::PS_DO, tolre_pkg::PS_DONT: begin
                        parse_next = tolre_pkg::PS_NORMAL;
                    end
                    tolre_pkg::PS_CLOSED: begin
                        parse_next = tolre_pkg::PS_CLOSED;
                    end
                    default: begin
                        parse_next = tolre_pkg::PS_NORMAL;
                    end
                endcase
                if (store) begin
                    fill_next = fill_reg + tolre_pkg::FILL_W'(1);
                    if (fill_reg == '0) begin
                        match_next = (s_tdata == tolre_pkg::quit_char(2'd0));
                    end else if (fill_reg < tolre_pkg::FILL_W'(4)) begin
                        match_next = match_reg &&
                                     (s_tdata == tolre_pkg::quit_char(fill_reg[1:0]));
                    end
                end
                if (line_end) begin
                    fill_next = '0;
                    if (quit_hit) begin
                        parse_next = tolre_pkg::PS_CLOSED;
                    end else begin
                        pend_next = 1'b1;
                    end
                end
            end
        end
    end

    // outputs
    always_comb begin
        q_push       = 1'b0;
        q_job.kind   = tolre_pkg::JOB_OPEN;
        q_job.arg    = s_tdata;
        q_job.len    = fill_reg;
        line_wr.en   = accept && store;
        line_wr.addr = fill_reg;
        line_wr.data = s_tdata;
        if (accept) begin
            if (s_tuser) begin
                q_push     = 1'b1;
                q_job.kind = tolre_pkg::JOB_OPEN;
            end else if ((parse_reg == tolre_pkg::PS_WILL) ||
                         (parse_reg == tolre_pkg::PS_WONT)) begin
                q_push     = 1'b1;
                q_job.kind = tolre_pkg::JOB_REF_DONT;
            end else if ((parse_reg == tolre_pkg::PS_DO) ||
                         (parse_reg == tolre_pkg::PS_DONT)) begin
                q_push     = 1'b1;
                q_job.kind = tolre_pkg::JOB_REF_WONT;
            end else if (line_end) begin
                q_push     = 1'b1;
                q_job.kind = quit_hit ? tolre_pkg::JOB_QUIT : tolre_pkg::JOB_ECHO;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parse_reg <= tolre_pkg::PS_NORMAL;
            fill_reg  <= '0;
            match_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            parse_reg <= parse_next;
            fill_reg  <= fill_next;
            match_reg <= match_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

`default_nettype wire

### hdl/tolre_queue.sv
// short job queue between the parser and the output sequencer
// depends on tolre_pkg
`default_nettype none

module tolre_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire tolre_pkg::job_t push_job,
    output logic                 full,
    input  wire logic            pop,
    output tolre_pkg::job_t      head,
    output logic                 empty
);

    localparam int PTR_W = (tolre_pkg::QUEUE_DEPTH > 1) ? $clog2(tolre_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(tolre_pkg::QUEUE_DEPTH + 1);

    tolre_pkg::job_t     slot_reg [tolre_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == CNT_W'(tolre_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(tolre_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(tolre_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### hdl/tolre_back.sv
// back end: line store, byte sequencer for each job and output register
// depends on tolre_pkg
`default_nettype none

module tolre_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                q_empty,
    output logic                     q_pop,
    input  wire tolre_pkg::job_t     q_head,
    input  wire tolre_pkg::line_wr_t line_wr,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [7:0]               m_tdata,
    output logic                     m_tlast,
    output logic                     m_tuser,
    output logic                     echo_done
);

    localparam int IDX_W  = tolre_pkg::IDX_W;
    localparam int FILL_W = tolre_pkg::FILL_W;
    localparam int ADDR_W = tolre_pkg::ADDR_W;

    logic [7:0]                  line_mem [tolre_pkg::LINE_LEN];
    logic [7:0]                  rd_data_reg;
    logic [ADDR_W-1:0]           rd_addr;

    tolre_pkg::phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    tolre_pkg::job_kind_t        kind_reg;
    logic [7:0]                  arg_reg;
    logic [FILL_W-1:0]           len_reg;

    logic                        out_valid_reg;
    logic [7:0]                  out_byte_reg;
    logic                        out_last_reg;
    logic                        out_closed_reg;

    logic                        emit;
    logic                        at_end;
    logic                        crlf_en;
    logic                        is_quit;
    logic [FILL_W-1:0]           len_m1;
    tolre_pkg::phase_t           follow;
    tolre_pkg::phase_t           start_phase;
    logic [7:0]                  byte_cur;
    logic                        last_cur;

    assign is_quit = (kind_reg == tolre_pkg::JOB_QUIT);
    assign len_m1  = len_reg - FILL_W'(1);
    assign crlf_en = len_reg < FILL_W'(tolre_pkg::LINE_LEN - 2);
    assign emit    = (phase_reg != tolre_pkg::PH_IDLE) && (!out_valid_reg || m_tready);

    // end of the current phase and what comes after it
    always_comb begin
        at_end = 1'b0;
        follow = tolre_pkg::PH_IDLE;
        unique case (phase_reg)
            tolre_pkg::PH_IDLE:   at_end = 1'b0;
            tolre_pkg::PH_OPEN:   at_end = (idx_reg == IDX_W'(4));
            tolre_pkg::PH_REFUSE: at_end = (idx_reg == IDX_W'(2));
            tolre_pkg::PH_LINE: begin
                at_end = (idx_reg == IDX_W'(len_m1));
                follow = crlf_en ? tolre_pkg::PH_CRLF : tolre_pkg::PH_PROMPT;
            end
            tolre_pkg::PH_CRLF: begin
                at_end = (idx_reg == IDX_W'(1));
                follow = tolre_pkg::PH_PROMPT;
            end
            tolre_pkg::PH_PROMPT: begin
                at_end = (idx_reg == IDX_W'(7));
                follow = is_quit ? tolre_pkg::PH_BYE : tolre_pkg::PH_IDLE;
            end
            tolre_pkg::PH_BYE:    at_end = (idx_reg == IDX_W'(8));
            default:              at_end = 1'b0;
        endcase
    end

    always_comb begin
        unique case (q_head.kind)
            tolre_pkg::JOB_OPEN:     start_phase = tolre_pkg::PH_OPEN;
            tolre_pkg::JOB_REF_DONT: start_phase = tolre_pkg::PH_REFUSE;
            tolre_pkg::JOB_REF_WONT: start_phase = tolre_pkg::PH_REFUSE;
            tolre_pkg::JOB_ECHO: begin
                start_phase = (q_head.len != '0) ? tolre_pkg::PH_LINE : tolre_pkg::PH_CRLF;
            end
            tolre_pkg::JOB_QUIT:     start_phase = tolre_pkg::PH_PROMPT;
            default:                 start_phase = tolre_pkg::PH_IDLE;
        endcase
    end

    // next state
    always_comb begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        q_pop      = 1'b0;
        if (phase_reg == tolre_pkg::PH_IDLE) begin
            if (!q_empty) begin
                q_pop      = 1'b1;
                phase_next = start_phase;
                idx_next   = '0;
            end
        end else if (emit) begin
            if (at_end) begin
                phase_next = follow;
                idx_next   = '0;
            end else begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    // outputs
    always_comb begin
        last_cur = at_end && (follow == tolre_pkg::PH_IDLE);
        unique case (phase_reg)
            tolre_pkg::PH_OPEN:   byte_cur = tolre_pkg::open_char(idx_reg[2:0]);
            tolre_pkg::PH_REFUSE: begin
                priority if (idx_reg == '0) begin
                    byte_cur = tolre_pkg::CMD_IAC;
                end else if (idx_reg == IDX_W'(1)) begin
                    byte_cur = (kind_reg == tolre_pkg::JOB_REF_DONT) ?
                               tolre_pkg::CMD_DONT : tolre_pkg::CMD_WONT;
                end else begin
                    byte_cur = arg_reg;
                end
            end
            tolre_pkg::PH_LINE:   byte_cur = rd_data_reg;
            tolre_pkg::PH_CRLF:   byte_cur = idx_reg[0] ? tolre_pkg::CH_LF : tolre_pkg::CH_CR;
            tolre_pkg::PH_PROMPT: byte_cur = tolre_pkg::prompt_char(idx_reg[2:0]);
            tolre_pkg::PH_BYE:    byte_cur = tolre_pkg::bye_char(idx_reg[3:0]);
            default:              byte_cur = 8'h00;
        endcase
        echo_done = emit && last_cur && (kind_reg == tolre_pkg::JOB_ECHO);
    end

    // read address follows the index so the read data lines up with it
    assign rd_addr = (phase_next == tolre_pkg::PH_LINE) ? idx_next[ADDR_W-1:0] : '0;

    always_ff @(posedge aclk) begin
        if (line_wr.en) begin
            line_mem[line_wr.addr] <= line_wr.data;
        end
        rd_data_reg <= line_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            kind_reg <= q_head.kind;
            arg_reg  <= q_head.arg;
            len_reg  <= q_head.len;
        end
        if (emit) begin
            out_byte_reg   <= byte_cur;
            out_last_reg   <= last_cur;
            out_closed_reg <= is_quit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= tolre_pkg::PH_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_closed_reg;

endmodule

`default_nettype wire

### hdl/telnet_option_refuse_line_echo_top.sv
// top level of the telnet line server with option refusal
// depends on tolre_pkg, tolre_front, tolre_queue and tolre_back
`default_nettype none

// channel   direction  tdata          tuser           tlast
// s_        in         rx_byte [7:0]  req_type        -
// m_        out        tx_byte [7:0]  session_closed  last byte of the run
//
// a word that produces no output (plain line byte, cr, option prefix) is taken
// while the job queue has room and no echo is pending
// a word that issues a job waits for a free slot in the two-entry job queue
// while a line echo is queued or running, input stalls until its last byte leaves the
// sequencer, since the echo reads the line store that new words would overwrite
// each job is popped while the sequencer is idle, then one output byte per cycle while m_tready is high
// reset is synchronous, active low; the line store needs no clearing pass

module telnet_option_refuse_line_echo_top (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
    input  wire logic       s_tuser,   // [0] req_type: 1 opens a connection
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] tx_byte
    output logic            m_tlast,
    output logic            m_tuser    // [0] session_closed
);

    tolre_pkg::job_t      q_job;
    tolre_pkg::job_t      q_head;
    tolre_pkg::line_wr_t  line_wr;
    logic                 q_push;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_empty;
    logic                 echo_done;

    // parser: option decoding and line gathering
    tolre_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_job),
        .line_wr   (line_wr),
        .echo_done (echo_done)
    );

    // jobs waiting for the sequencer
    tolre_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_job),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    // sequencer: expands each job into its byte run
    tolre_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_head    (q_head),
        .line_wr   (line_wr),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .echo_done (echo_done)
    );

endmodule

`default_nettype wire

### tb/sv/tb_telnet_option_refuse_line_echo_top.sv
// self-checking testbench for the telnet line server with option refusal
// depends on tolre_pkg and telnet_option_refuse_line_echo_top; needs nothing else
// drives received bytes in random bursts, predicts every outbound byte and checks it
`default_nettype none

module tb_telnet_option_refuse_line_echo_top;

    localparam int CYCLE_LIMIT  = 1_000_000;  // generous bound on the whole run
    localparam int SETTLE_CYCLE = 8;          // quiet cycles before a held word goes out
    localparam int TAIL_CYCLES  = 60;         // watch for stray output after the last reply
    localparam int WORD_TARGET  = 280;

    // outbound text and the quit command, first character in the highest byte
    localparam logic [63:0] PROMPT_TXT = "wizard> ";
    localparam logic [39:0] GREET_TXT  = 40'h62_65_65_3e_20;
    localparam logic [55:0] BYE_TXT    = "goodbye";
    localparam logic [31:0] QUIT_TXT   = "quit";

    typedef enum logic [1:0] {
        PACE_FULL,
        PACE_HALF,
        PACE_SPARSE,
        PACE_HOLD
    } rx_pace_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
        logic       drain;     // hold this word until every reply has left
    } rx_word_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
        logic       closed;
    } tx_word_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] rx_byte
    logic       s_tuser  = 1'b0;    // [0] req_type
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] tx_byte
    logic       m_tlast;
    logic       m_tuser;            // [0] session_closed

    rx_word_t   rx_words[$];        // words still to be offered
    tx_word_t   reply_bytes_due[$]; // outbound bytes predicted but not yet seen
    logic [7:0] run_bytes[$];       // bytes of the run being predicted

    // server state mirrored by the predictor
    tolre_pkg::parse_state_t srv_state;
    logic [7:0]              srv_line[tolre_pkg::LINE_LEN];
    int                      srv_fill;

    int       cycle_count  = 0;
    int       quiet_cycles = 0;
    int       fault_count  = 0;
    int       word_total   = 0;
    logic     s_taken      = 1'b0;
    logic     hold_next    = 1'b0;
    int       burst_left   = 1;
    int       gap_left     = 0;
    rx_pace_t pace         = PACE_FULL;
    int       pace_span    = 0;
    tx_word_t want;

    telnet_option_refuse_line_echo_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // ---------------------------------------------------------------- predictor

    function automatic void emit_text(input logic [63:0] txt, input int n);
        for (int i = 0; i < n; i++) begin
            run_bytes.push_back(txt[8*(n-1-i) +: 8]);
        end
    endfunction

    // one data byte into the line; lf or a full line flushes it
    function automatic void line_take(input logic [7:0] c);
        int len;
        if (c == tolre_pkg::CH_CR) begin
            return;
        end
        if (c != tolre_pkg::CH_LF && srv_fill != tolre_pkg::LINE_LEN - 1) begin
            srv_line[srv_fill] = c;
            srv_fill++;
            return;
        end
        len = srv_fill;
        srv_fill = 0;
        if (len == 4 && {srv_line[0], srv_line[1], srv_line[2], srv_line[3]} == QUIT_TXT) begin
            srv_state = tolre_pkg::PS_CLOSED;
        end else begin
            for (int i = 0; i < len; i++) begin
                run_bytes.push_back(srv_line[i]);
            end
            // short lines get cr lf, the two longest lengths do not
            if (len < tolre_pkg::LINE_LEN - 2) begin
                run_bytes.push_back(tolre_pkg::CH_CR);
                run_bytes.push_back(tolre_pkg::CH_LF);
            end
        end
        emit_text(PROMPT_TXT, 8);
    endfunction

    // works out the whole run caused by one accepted word
    function automatic void server_step(input logic req_type, input logic [7:0] c);
        tolre_pkg::parse_state_t was;
        logic                    closing;
        closing = 1'b0;
        was = srv_state;
        run_bytes.delete();
        if (req_type) begin
            srv_state = tolre_pkg::PS_NORMAL;
            srv_fill  = 0;
            emit_text(GREET_TXT, 5);
        end else begin
            case (srv_state)
                tolre_pkg::PS_NORMAL: begin
                    if (c == tolre_pkg::CMD_IAC) srv_state = tolre_pkg::PS_IAC;
                    else line_take(c);
                end
                tolre_pkg::PS_IAC: begin
                    if (c == tolre_pkg::CMD_IAC) begin
                        srv_state = tolre_pkg::PS_NORMAL;
                        line_take(c);
                    end else if (c == tolre_pkg::CMD_WILL) begin
                        srv_state = tolre_pkg::PS_WILL;
                    end else if (c == tolre_pkg::CMD_WONT) begin
                        srv_state = tolre_pkg::PS_WONT;
                    end else if (c == tolre_pkg::CMD_DO) begin
                        srv_state = tolre_pkg::PS_DO;
                    end else if (c == tolre_pkg::CMD_DONT) begin
                        srv_state = tolre_pkg::PS_DONT;
                    end else begin
                        srv_state = tolre_pkg::PS_NORMAL;
                    end
                end
                tolre_pkg::PS_WILL, tolre_pkg::PS_WONT: begin
                    run_bytes.push_back(tolre_pkg::CMD_IAC);
                    run_bytes.push_back(tolre_pkg::CMD_DONT);
                    run_bytes.push_back(c);
                    srv_state = tolre_pkg::PS_NORMAL;
                end
                tolre_pkg::PS_DO, tolre_pkg::PS_DONT: begin
                    run_bytes.push_back(tolre_pkg::CMD_IAC);
                    run_bytes.push_back(tolre_pkg::CMD_WONT);
                    run_bytes.push_back(c);
                    srv_state = tolre_pkg::PS_NORMAL;
                end
                tolre_pkg::PS_CLOSED: ;
                default: srv_state = tolre_pkg::PS_NORMAL;
            endcase
            // quit just matched: goodbye follows the prompt
            if (was != tolre_pkg::PS_CLOSED && srv_state == tolre_pkg::PS_CLOSED) begin
                closing = 1'b1;
                emit_text(BYE_TXT, 7);
                run_bytes.push_back(tolre_pkg::CH_CR);
                run_bytes.push_back(tolre_pkg::CH_LF);
            end
        end
        foreach (run_bytes[i]) begin
            reply_bytes_due.push_back('{tx_byte: run_bytes[i],
                                        last:    (i == run_bytes.size() - 1),
                                        closed:  closing});
        end
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic void push_word(input logic req_type, input logic [7:0] c,
                                      input logic counted);
        rx_words.push_back('{req_type: req_type, rx_byte: c, drain: hold_next});
        hold_next = 1'b0;
        if (counted) word_total++;
    endfunction

    // a data byte as the peer would send it, with 255 escaped
    function automatic void push_data(input logic [7:0] c);
        if (c == tolre_pkg::CMD_IAC) push_word(1'b0, tolre_pkg::CMD_IAC, 1'b1);
        push_word(1'b0, c, 1'b1);
    endfunction

    // ---------------------------------------------------------------- driver

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_taken) begin
            // word still on offer, keep it steady
        end else if (gap_left > 0) begin
            gap_left--;
            s_tvalid <= 1'b0;
        end else if (rx_words.size() == 0) begin
            s_tvalid <= 1'b0;
        end else if (rx_words[0].drain &&
                     !(reply_bytes_due.size() == 0 && quiet_cycles >= SETTLE_CYCLE)) begin
            s_tvalid <= 1'b0;
        end else begin
            s_tvalid <= 1'b1;
            s_tdata  <= rx_words[0].rx_byte;
            s_tuser  <= rx_words[0].req_type;
            void'(rx_words.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
                // long unbroken bursts now and then, otherwise short ones
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90)
                                                         : $urandom_range(1, 16);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            end
        end
    end

    // receiver back-pressure, with a pace that is picked anew at random
    always @(negedge aclk) begin
        if (pace_span == 0) begin
            pace      = rx_pace_t'($urandom_range(0, 3));
            pace_span = $urandom_range(8, 80);
        end else begin
            pace_span--;
        end
        case (pace)
            PACE_FULL:   m_tready <= 1'b1;
            PACE_HALF:   m_tready <= 1'($urandom_range(0, 1));
            PACE_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:     m_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d bytes still due", $time, reply_bytes_due.size());
            $display("telnet_option_refuse_line_echo_top test failed");
            $finish;
        end else if (aresetn) begin
            s_taken = s_tvalid && s_tready;
            // check before predicting so a byte can never meet its own prediction
            if (m_tvalid && m_tready) begin
                if (reply_bytes_due.size() == 0) begin
                    $display("%0t unexpected word: expected none, actual tx_byte %h last %b closed %b",
                             $time, m_tdata, m_tlast, m_tuser);
                    fault_count++;
                end else begin
                    want = reply_bytes_due.pop_front();
                    if (m_tdata !== want.tx_byte) begin
                        $display("%0t tx_byte mismatch: expected %h actual %h",
                                 $time, want.tx_byte, m_tdata);
                        fault_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t last mismatch: expected %b actual %b",
                                 $time, want.last, m_tlast);
                        fault_count++;
                    end
                    if (m_tuser !== want.closed) begin
                        $display("%0t session_closed mismatch: expected %b actual %b",
                                 $time, want.closed, m_tuser);
                        fault_count++;
                    end
                end
            end
            if (s_taken) server_step(s_tuser, s_tdata);
            if (reply_bytes_due.size() == 0) quiet_cycles++;
            else quiet_cycles = 0;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin : stimulus
        int         pick;
        int         len;
        logic [7:0] c;

        srv_state = tolre_pkg::PS_NORMAL;
        srv_fill  = 0;

        // directed part: open, empty line, every refusal, dropped command,
        // escaped 255, zero byte, cr, then quit, a byte into the closed session and a new open
        push_word(1'b1, 8'($urandom_range(0, 255)), 1'b1);
        push_word(1'b0, tolre_pkg::CH_LF, 1'b1);
        push_word(1'b0, tolre_pkg::CMD_IAC, 1'b1);
        push_word(1'b0, tolre_pkg::CMD_WILL, 1'b1);
        push_word(1'b0, 8'h00, 1'b1);
        push_word(1'b0, tolre_pkg::CMD_IAC, 1'b1);
        push_word(1'b0, tolre_pkg::CMD_WONT, 1'b1);
        push_word(1'b0, 8'hff, 1'b1);
        push_word(1'b0, tolre_pkg::CMD_IAC, 1'b1);
        push_word(1'b0, tolre_pkg::CMD_DO, 1'b1);
        push_word(1'b0, 8'h01, 1'b1);
        push_word(1'b0, tolre_pkg::CMD_IAC, 1'b1);
        push_word(1'b0, tolre_pkg::CMD_DONT, 1'b1);
        push_word(1'b0, 8'h80, 1'b1);
        push_word(1'b0, tolre_pkg::CMD_IAC, 1'b1);
        push_word(1'b0, 8'hf0, 1'b1);
        push_data(8'hff);
        push_word(1'b0, 8'h00, 1'b1);
        push_word(1'b0, tolre_pkg::CH_CR, 1'b1);
        push_word(1'b0, tolre_pkg::CH_LF, 1'b1);
        for (int i = 0; i < 4; i++) push_word(1'b0, QUIT_TXT[8*(3-i) +: 8], 1'b1);
        push_word(1'b0, tolre_pkg::CH_LF, 1'b1);
        push_word(1'b0, tolre_pkg::CMD_IAC, 1'b0);
        push_word(1'b1, 8'($urandom_range(0, 255)), 1'b1);

        // random part, first word waits for the directed replies to drain
        hold_next = 1'b1;
        while (word_total < WORD_TARGET) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 39) == 0) hold_next = 1'b1;
            if (pick < 45) begin
                // a line; lengths bunch up near the full-line boundary
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: len = $urandom_range(0, 8);
                    6, 7, 8:          len = $urandom_range(tolre_pkg::LINE_LEN - 6,
                                                           tolre_pkg::LINE_LEN + 4);
                    default:          len = $urandom_range(1, tolre_pkg::LINE_LEN - 7);
                endcase
                for (int i = 0; i < len; i++) begin
                    c = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(8'h20, 8'h7e));
                    push_data(c);
                end
                if ($urandom_range(0, 1)) push_word(1'b0, tolre_pkg::CH_CR, 1'b1);
                push_word(1'b0, tolre_pkg::CH_LF, 1'b1);
            end else if (pick < 62) begin
                // option negotiation or some other command
                push_word(1'b0, tolre_pkg::CMD_IAC, 1'b1);
                case ($urandom_range(0, 4))
                    0: push_word(1'b0, tolre_pkg::CMD_WILL, 1'b1);
                    1: push_word(1'b0, tolre_pkg::CMD_WONT, 1'b1);
                    2: push_word(1'b0, tolre_pkg::CMD_DO, 1'b1);
                    3: push_word(1'b0, tolre_pkg::CMD_DONT, 1'b1);
                    default: push_word(1'b0, 8'($urandom_range(0, 250)), 1'b1);
                endcase
                if (pick < 58) push_word(1'b0, 8'($urandom_range(0, 255)), 1'b1);
            end else if (pick < 70) begin
                // quit, or something close to it
                push_word(1'b0, tolre_pkg::CH_LF, 1'b1);
                len = $urandom_range(0, 9);
                for (int i = 0; i < 4; i++) begin
                    if (!(len == 7 && i == 3)) begin
                        c = QUIT_TXT[8*(3-i) +: 8];
                        if (len == 8 && i == 0) c = c ^ 8'h20;
                        push_word(1'b0, c, 1'b1);
                    end
                end
                if (len == 9) push_word(1'b0, 8'($urandom_range(8'h21, 8'h7e)), 1'b1);
                if ($urandom_range(0, 1)) push_word(1'b0, tolre_pkg::CH_CR, 1'b1);
                push_word(1'b0, tolre_pkg::CH_LF, 1'b1);
                if (len < 7) begin
                    // closed session swallows these
                    repeat ($urandom_range(1, 4)) begin
                        push_word(1'b0, 8'($urandom_range(0, 255)), 1'b0);
                    end
                    push_word(1'b1, 8'($urandom_range(0, 255)), 1'b1);
                end
            end else if (pick < 75) begin
                push_word(1'b1, 8'($urandom_range(0, 255)), 1'b1);
            end else begin
                repeat ($urandom_range(1, 6)) push_word(1'b0, 8'($urandom_range(0, 255)), 1'b1);
            end
        end

        // hold reset, then release it on a falling edge
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // every word offered and taken
        @(posedge aclk);
        while (rx_words.size() != 0 || s_tvalid) @(posedge aclk);
        // every predicted byte seen
        @(negedge aclk);
        while (reply_bytes_due.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (fault_count == 0 && reply_bytes_due.size() == 0) begin
            $display("telnet_option_refuse_line_echo_top test passed");
        end else begin
            $display("telnet_option_refuse_line_echo_top test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
hdl/tolre_pkg.sv
hdl/tolre_front.sv
hdl/tolre_queue.sv
hdl/tolre_back.sv
hdl/telnet_option_refuse_line_echo_top.sv
tb/sv/tb_telnet_option_refuse_line_echo_top.sv
